// ===== sv/brsc_pkg.sv =====
// Shared constants, command and status codes, and controller/datapath interface types.
package brsc_pkg;

   localparam int NUM_PROCS_DEF  = 8;
   localparam int NUM_RES_DEF    = 3;
   localparam int COUNT_BITS_DEF = 8;
   localparam int OUT_LIMIT      = 8;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_AVAIL   = 2'd1;
   localparam logic [1:0] CMD_REQUEST = 2'd2;
   localparam logic [1:0] CMD_CHECK   = 2'd3;

   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_OVER_NEED  = 3'd1;
   localparam logic [2:0] ST_OVER_AVAIL = 3'd2;
   localparam logic [2:0] ST_UNSAFE_RB  = 3'd3;
   localparam logic [2:0] ST_SAFE       = 3'd4;
   localparam logic [2:0] ST_UNSAFE     = 3'd5;
   localparam logic [2:0] ST_LOADED     = 3'd6;
   localparam logic [2:0] ST_REJECTED   = 3'd7;

   typedef struct packed {
      logic       cap;
      logic       do_load;
      logic       do_avail;
      logic       do_grant;
      logic       do_rollback;
      logic       scan_init;
      logic       scan_step;
      logic       emit_rd;
      logic       out_load;
      logic       out_seq;
      logic [2:0] status;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       load_ok;
      logic       avail_ok;
      logic       over_need;
      logic       over_avail;
      logic       scan_done;
      logic       scan_fail;
      logic       emit_last;
      logic       rsp_free;
   } sts_type;

endpackage

// ===== sv/brsc_ctrl.sv =====
// Controller state machine sequencing decode, safety scan, rollback and result transfers.
module brsc_ctrl import brsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_SCAN_INIT = 3'd2;
   localparam logic [2:0] S_SCAN      = 3'd3;
   localparam logic [2:0] S_ROLLBACK  = 3'd4;
   localparam logic [2:0] S_RESP      = 3'd5;
   localparam logic [2:0] S_EMIT_RD   = 3'd6;
   localparam logic [2:0] S_EMIT_WR   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stat_ff  <= ST_GRANTED;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   always_comb begin
      ctl        = '0;
      ctl.status = stat_ff;
      state_in   = state_ff;
      stat_in    = stat_ff;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cap  = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.cmd)
               CMD_LOAD: begin
                  ctl.do_load = 1'b1;
                  stat_in     = sts.load_ok ? ST_LOADED : ST_REJECTED;
                  state_in    = S_RESP;
               end
               CMD_AVAIL: begin
                  ctl.do_avail = 1'b1;
                  stat_in      = sts.avail_ok ? ST_LOADED : ST_REJECTED;
                  state_in     = S_RESP;
               end
               CMD_CHECK: begin
                  stat_in  = ST_SAFE;
                  state_in = S_SCAN_INIT;
               end
               default: begin
                  if (sts.over_need) begin
                     stat_in  = ST_OVER_NEED;
                     state_in = S_RESP;
                  end else if (sts.over_avail) begin
                     stat_in  = ST_OVER_AVAIL;
                     state_in = S_RESP;
                  end else begin
                     ctl.do_grant = 1'b1;
                     stat_in      = ST_GRANTED;
                     state_in     = S_SCAN_INIT;
                  end
               end
            endcase
         end
         S_SCAN_INIT: begin
            ctl.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_EMIT_RD;
            end else if (sts.scan_fail) begin
               if (stat_ff == ST_GRANTED) begin
                  stat_in  = ST_UNSAFE_RB;
                  state_in = S_ROLLBACK;
               end else begin
                  stat_in  = ST_UNSAFE;
                  state_in = S_RESP;
               end
            end
         end
         S_ROLLBACK: begin
            ctl.do_rollback = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT_RD: begin
            ctl.emit_rd = 1'b1;
            state_in    = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (sts.rsp_free) begin
               ctl.out_load = 1'b1;
               ctl.out_seq  = 1'b1;
               state_in     = sts.emit_last ? S_IDLE : S_EMIT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== sv/brsc_dp.sv =====
// Datapath: allocation/need tables, free counts, scan work vector, safe sequence, result register.
module brsc_dp import brsc_pkg::*; #(
   parameter int NUM_PROCS  = NUM_PROCS_DEF,
   parameter int NUM_RES    = NUM_RES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  ctl_type    ctl,
   output sts_type    sts,
   input  logic [1:0] req_cmd,
   input  logic [2:0] req_process,
   input  logic [1:0] req_resource,
   input  logic [7:0] req_max_value,
   input  logic [7:0] req_alloc_value,
   input  logic [7:0] req_avail_value,
   input  logic [7:0] req_req_0,
   input  logic [7:0] req_req_1,
   input  logic [7:0] req_req_2,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_seq_process,
   output logic       rsp_last
);

   localparam int PW   = $clog2(NUM_PROCS);
   localparam int RW   = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int CNTW = $clog2(NUM_PROCS + 1);
   localparam int WW   = COUNT_BITS + CNTW;
   localparam int CW   = (COUNT_BITS > 8) ? COUNT_BITS : 8;
   localparam int NOUT = (NUM_PROCS < OUT_LIMIT) ? NUM_PROCS : OUT_LIMIT;
   localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << COUNT_BITS) - 64'd1);

   logic [COUNT_BITS-1:0] alloc_ff [NUM_PROCS][NUM_RES];
   logic [COUNT_BITS-1:0] need_ff  [NUM_PROCS][NUM_RES];
   logic [COUNT_BITS-1:0] avail_ff [NUM_RES];
   logic [WW-1:0]         work_ff  [NUM_RES];
   logic [NUM_PROCS-1:0]  fin_ff;
   logic [PW-1:0]         seq_mem  [NUM_PROCS];
   logic [PW-1:0]         rd_ff;
   logic [PW-1:0]         idx_ff;
   logic [CNTW-1:0]       count_ff;
   logic [CNTW-1:0]       k_ff;
   logic                  took_ff;

   logic [1:0] cmd_ff;
   logic [2:0] proc_ff;
   logic [1:0] res_ff;
   logic [7:0] max_ff, al_ff, av_ff;
   logic [7:0] reqv_ff [3];

   logic       rsp_valid_ff;
   logic [2:0] rsp_status_ff, rsp_seq_ff;
   logic       rsp_last_ff;

   logic [PW-1:0] cap_p;
   logic [RW-1:0] cap_r;
   logic          proc_ok, res_ok;
   logic          fits, take, pass_end;
   logic [CNTW-1:0] count_nx;

   assign cap_p   = PW'(proc_ff);
   assign cap_r   = RW'(res_ff);
   assign proc_ok = 32'(proc_ff) < NUM_PROCS;
   assign res_ok  = 32'(res_ff) < NUM_RES;

   always_comb begin
      sts            = '0;
      sts.cmd        = cmd_ff;
      sts.load_ok    = proc_ok && res_ok && (al_ff <= max_ff) && (CW'(max_ff) <= CNT_MAX);
      sts.avail_ok   = res_ok;
      sts.over_need  = !proc_ok;
      sts.over_avail = 1'b0;
      fits           = 1'b1;
      for (int j = 0; j < NUM_RES; j++) begin
         if (CW'(reqv_ff[j]) > CW'(need_ff[cap_p][j])) sts.over_need = 1'b1;
         if (CW'(reqv_ff[j]) > CW'(avail_ff[j]))       sts.over_avail = 1'b1;
         if (WW'(need_ff[idx_ff][j]) > work_ff[j])     fits = 1'b0;
      end
      take          = !fin_ff[idx_ff] && fits;
      count_nx      = count_ff + CNTW'(take);
      pass_end      = idx_ff == PW'(NUM_PROCS - 1);
      sts.scan_done = count_nx == CNTW'(NUM_PROCS);
      sts.scan_fail = pass_end && !(took_ff || take) && !sts.scan_done;
      sts.emit_last = k_ff == CNTW'(NOUT - 1);
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // capture the accepted transfer
   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         cmd_ff     <= req_cmd;
         proc_ff    <= req_process;
         res_ff     <= req_resource;
         max_ff     <= req_max_value;
         al_ff      <= req_alloc_value;
         av_ff      <= req_avail_value;
         reqv_ff[0] <= req_req_0;
         reqv_ff[1] <= req_req_1;
         reqv_ff[2] <= req_req_2;
      end
   end

   // tables and free counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PROCS; i++) begin
            for (int j = 0; j < NUM_RES; j++) begin
               alloc_ff[i][j] <= '0;
               need_ff[i][j]  <= '0;
            end
         end
         for (int j = 0; j < NUM_RES; j++) avail_ff[j] <= '0;
      end else begin
         if (ctl.do_load && sts.load_ok) begin
            alloc_ff[cap_p][cap_r] <= COUNT_BITS'(al_ff);
            need_ff[cap_p][cap_r]  <= COUNT_BITS'(max_ff - al_ff);
         end
         if (ctl.do_avail && res_ok) begin
            avail_ff[cap_r] <= COUNT_BITS'((CW'(av_ff) > CNT_MAX) ? CNT_MAX : CW'(av_ff));
         end
         if (ctl.do_grant) begin
            for (int j = 0; j < NUM_RES; j++) begin
               avail_ff[j]        <= avail_ff[j] - COUNT_BITS'(reqv_ff[j]);
               alloc_ff[cap_p][j] <= alloc_ff[cap_p][j] + COUNT_BITS'(reqv_ff[j]);
               need_ff[cap_p][j]  <= need_ff[cap_p][j] - COUNT_BITS'(reqv_ff[j]);
            end
         end
         if (ctl.do_rollback) begin
            for (int j = 0; j < NUM_RES; j++) begin
               avail_ff[j]        <= avail_ff[j] + COUNT_BITS'(reqv_ff[j]);
               alloc_ff[cap_p][j] <= alloc_ff[cap_p][j] - COUNT_BITS'(reqv_ff[j]);
               need_ff[cap_p][j]  <= need_ff[cap_p][j] + COUNT_BITS'(reqv_ff[j]);
            end
         end
      end
   end

   // safety scan, one process per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff   <= '0;
         idx_ff   <= '0;
         count_ff <= '0;
         took_ff  <= 1'b0;
         k_ff     <= '0;
         for (int j = 0; j < NUM_RES; j++) work_ff[j] <= '0;
      end else begin
         if (ctl.scan_init) begin
            fin_ff   <= '0;
            idx_ff   <= '0;
            count_ff <= '0;
            took_ff  <= 1'b0;
            k_ff     <= '0;
            for (int j = 0; j < NUM_RES; j++) work_ff[j] <= WW'(avail_ff[j]);
         end else if (ctl.scan_step) begin
            if (take) begin
               for (int j = 0; j < NUM_RES; j++) begin
                  work_ff[j] <= work_ff[j] + WW'(alloc_ff[idx_ff][j]);
               end
               fin_ff[idx_ff] <= 1'b1;
            end
            count_ff <= count_nx;
            idx_ff   <= pass_end ? '0 : idx_ff + PW'(1);
            took_ff  <= pass_end ? 1'b0 : (took_ff || take);
         end
         if (ctl.out_load && ctl.out_seq) k_ff <= k_ff + CNTW'(1);
      end
   end

   // safe sequence store
   always_ff @(posedge clock) begin
      if (ctl.scan_step && take) seq_mem[count_ff[PW-1:0]] <= idx_ff;
      if (ctl.emit_rd) rd_ff <= seq_mem[k_ff[PW-1:0]];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_status_ff <= ctl.status;
         rsp_seq_ff    <= ctl.out_seq ? 3'(rd_ff) : 3'd0;
         rsp_last_ff   <= ctl.out_seq ? sts.emit_last : 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_seq_process = rsp_seq_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== sv/bankers_request_safety_check.sv =====
// Top level of the banker's-algorithm request and safety checker.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  cmd, process, resource, values, req_0..2
//   rsp_     out        rsp_valid / rsp_ready  status, seq_process, last
//
// Load and set-available pass through decode and the result state to the output transfer.
// A request or check runs a scan of one process per cycle, in up to NUM_PROCS passes
// over all processes; each sequence result is then read from the store and sent.
// Reset is synchronous and clears all tables, free counts and control state.
// A stalled rsp_ready holds the controller; one item is in work at a time.
module bankers_request_safety_check import brsc_pkg::*; #(
   parameter int NUM_PROCS  = NUM_PROCS_DEF,
   parameter int NUM_RES    = NUM_RES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [2:0] req_process,
   input  logic [1:0] req_resource,
   input  logic [7:0] req_max_value,
   input  logic [7:0] req_alloc_value,
   input  logic [7:0] req_avail_value,
   input  logic [7:0] req_req_0,
   input  logic [7:0] req_req_1,
   input  logic [7:0] req_req_2,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_seq_process,
   output logic       rsp_last
);

   ctl_type ctl;
   sts_type sts;

   brsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   brsc_dp #(
      .NUM_PROCS  (NUM_PROCS),
      .NUM_RES    (NUM_RES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_process     (req_process),
      .req_resource    (req_resource),
      .req_max_value   (req_max_value),
      .req_alloc_value (req_alloc_value),
      .req_avail_value (req_avail_value),
      .req_req_0       (req_req_0),
      .req_req_1       (req_req_1),
      .req_req_2       (req_req_2),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_seq_process (rsp_seq_process),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== sv/brsc_checker.sv =====
// Port-level checker for the request and safety checker, with its bind.
module brsc_checker import brsc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [2:0] rsp_seq_process,
   input logic       rsp_last
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_seq_process) && $stable(rsp_last))
      else $error("stalled result changed");

   a_refusal_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OVER_NEED || rsp_status == ST_OVER_AVAIL
         || rsp_status == ST_UNSAFE_RB || rsp_status == ST_UNSAFE
         || rsp_status == ST_LOADED || rsp_status == ST_REJECTED)
      |-> rsp_last && rsp_seq_process == 3'd0)
      else $error("single-result status without last or with sequence entry");

   a_no_accept_mid_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input accepted while sequence in flight");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after input transfer");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bankers_request_safety_check brsc_checker u_brsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_seq_process (rsp_seq_process),
   .rsp_last        (rsp_last)
);

// ===== test/bankers_request_safety_check_test.sv =====
// Testbench for the banker's-algorithm request and safety checker.
`timescale 1ns / 100ps

module bankers_request_safety_check_test;
   import brsc_pkg::*;

   localparam int NP = 8;
   localparam int NR = 3;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] seq_process;
      logic       last;
   } outcome_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_cmd = CMD_LOAD;
   logic [2:0] req_process = '0;
   logic [1:0] req_resource = '0;
   logic [7:0] req_max_value = '0;
   logic [7:0] req_alloc_value = '0;
   logic [7:0] req_avail_value = '0;
   logic [7:0] req_req_0 = '0;
   logic [7:0] req_req_1 = '0;
   logic [7:0] req_req_2 = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [2:0] rsp_seq_process;
   logic       rsp_last;

   // predictor state
   logic [7:0]  held[NP][NR];
   logic [7:0]  owed[NP][NR];
   logic [7:0]  free_units[NR];
   logic [2:0]  order[NP];
   outcome_t    pending_outcomes[$];
   int          failures = 0;
   int          burst_left = 0;
   int          stall_mode = 0;

   bankers_request_safety_check i_dut (.*);

   always #2 clock = ~clock;

   function automatic bit scan_is_safe();
      logic [11:0] work[NR];
      bit          done[NP];
      int          count;
      bit          took;
      bit          fits;
      count = 0;
      for (int j = 0; j < NR; j++) work[j] = 12'(free_units[j]);
      for (int i = 0; i < NP; i++) done[i] = 1'b0;
      while (count < NP) begin
         took = 1'b0;
         for (int i = 0; i < NP; i++) begin
            if (done[i]) continue;
            fits = 1'b1;
            for (int j = 0; j < NR; j++)
               if (12'(owed[i][j]) > work[j]) fits = 1'b0;
            if (fits) begin
               for (int j = 0; j < NR; j++) work[j] = work[j] + 12'(held[i][j]);
               done[i] = 1'b1;
               order[count] = i[2:0];
               count++;
               took = 1'b1;
            end
         end
         if (!took) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void push_single(logic [2:0] st);
      pending_outcomes.push_back('{st, 3'd0, 1'b1});
   endfunction

   function automatic void push_sequence(logic [2:0] st);
      for (int k = 0; k < NP; k++)
         pending_outcomes.push_back('{st, order[k], k == NP - 1});
   endfunction

   function automatic void predict_allocator(logic [1:0] cmd, logic [2:0] p, logic [1:0] r,
                                             logic [7:0] mx, logic [7:0] al, logic [7:0] av,
                                             logic [7:0] q0, logic [7:0] q1, logic [7:0] q2);
      logic [7:0] want[NR];
      want[0] = q0; want[1] = q1; want[2] = q2;
      case (cmd)
         CMD_LOAD: begin
            if (r >= NR || al > mx) push_single(ST_REJECTED);
            else begin
               held[p][r] = al;
               owed[p][r] = mx - al;
               push_single(ST_LOADED);
            end
         end
         CMD_AVAIL: begin
            if (r >= NR) push_single(ST_REJECTED);
            else begin
               free_units[r] = av;
               push_single(ST_LOADED);
            end
         end
         CMD_CHECK: begin
            if (scan_is_safe()) push_sequence(ST_SAFE);
            else push_single(ST_UNSAFE);
         end
         default: begin
            for (int j = 0; j < NR; j++)
               if (want[j] > owed[p][j]) begin
                  push_single(ST_OVER_NEED);
                  return;
               end
            for (int j = 0; j < NR; j++)
               if (want[j] > free_units[j]) begin
                  push_single(ST_OVER_AVAIL);
                  return;
               end
            for (int j = 0; j < NR; j++) begin
               free_units[j] -= want[j];
               held[p][j] += want[j];
               owed[p][j] -= want[j];
            end
            if (scan_is_safe()) push_sequence(ST_GRANTED);
            else begin
               for (int j = 0; j < NR; j++) begin
                  free_units[j] += want[j];
                  held[p][j] -= want[j];
                  owed[p][j] += want[j];
               end
               push_single(ST_UNSAFE_RB);
            end
         end
      endcase
   endfunction

   // Send one item; bursts with random gaps, gap taken before raising valid.
   task automatic send_item(logic [1:0] cmd, logic [2:0] p, logic [1:0] r,
                            logic [7:0] mx, logic [7:0] al, logic [7:0] av,
                            logic [7:0] q0, logic [7:0] q1, logic [7:0] q2);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= cmd; req_process <= p; req_resource <= r;
      req_max_value <= mx; req_alloc_value <= al; req_avail_value <= av;
      req_req_0 <= q0; req_req_1 <= q1; req_req_2 <= q2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_allocator(cmd, p, r, mx, al, av, q0, q1, q2);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic load_entry(int p, int r, int mx, int al);
      send_item(CMD_LOAD, 3'(p), 2'(r), 8'(mx), 8'(al), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
   endtask

   task automatic set_free(int r, int av);
      send_item(CMD_AVAIL, 3'($urandom), 2'(r), 8'($urandom), 8'($urandom), 8'(av),
                8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic request_units(int p, int q0, int q1, int q2);
      send_item(CMD_REQUEST, 3'(p), 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'(q0), 8'(q1), 8'(q2));
   endtask

   task automatic run_safety_check();
      send_item(CMD_CHECK, 3'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_directed();
      run_safety_check();                     // all zero: safe, order 0..7
      load_entry(7, 2, 255, 255);
      load_entry(0, 0, 255, 0);
      load_entry(1, 3, 10, 5);                // bad resource
      load_entry(2, 1, 5, 6);                 // alloc over max
      set_free(3, 9);                         // bad resource
      set_free(0, 255);
      set_free(1, 0);
      run_safety_check();
      request_units(0, 255, 0, 0);            // fits need and free
      load_entry(3, 1, 200, 100);
      request_units(3, 0, 101, 0);            // over need
      request_units(3, 0, 50, 0);             // over free
      set_free(1, 20);
      set_free(0, 0);
      load_entry(0, 0, 255, 0);
      load_entry(4, 0, 50, 0);
      request_units(4, 0, 0, 0);              // zero request; unsafe while p0 owes 255
      run_safety_check();
      set_free(0, 255);
      request_units(3, 0, 20, 0);             // leaves 80 owed with nothing free: rolled back
      request_units(3, 0, 10, 0);
      run_safety_check();
      drain();
   endtask

   // Load a small random system, then mostly requests and checks on it.
   task automatic test_random_sessions();
      int p, kind;
      for (int s = 0; s < 12; s++) begin
         for (int i = 0; i < 4; i++) begin
            p = $urandom_range(0, NP - 1);
            kind = $urandom_range(0, 3);
            load_entry(p, $urandom_range(0, 2), $urandom_range(0, 30) + (kind == 0 ? 225 : 0),
                       $urandom_range(0, 20));
         end
         for (int r = 0; r < NR; r++)
            set_free(r, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
         for (int i = 0; i < 20; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
               request_units($urandom_range(0, NP - 1), $urandom_range(0, 12),
                             $urandom_range(0, 12), $urandom_range(0, 12));
            else if (kind < 8) run_safety_check();
            else send_item(2'($urandom), 3'($urandom), 2'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
         end
         if (s % 4 == 3) drain();
      end
      drain();
   endtask

   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   always @(posedge clock) begin
      outcome_t got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_seq_process, rsp_last};
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               failures++;
            end
            if (got.seq_process !== want.seq_process) begin
               $display("%0t: seq_process expected %0d actual %0d", $time,
                        want.seq_process, got.seq_process);
               failures++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
               failures++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NP; i++)
         for (int j = 0; j < NR; j++) begin
            held[i][j] = '0;
            owed[i][j] = '0;
         end
      for (int j = 0; j < NR; j++) free_units[j] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sessions();
      if (failures == 0 && pending_outcomes.size() == 0)
         $display("[bankers_request_safety_check] OK");
      else
         $display("[bankers_request_safety_check] ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("[bankers_request_safety_check] ERROR");
      $finish;
   end

endmodule
